// ===== hdl/i2c_master_register_sequencer_unit_defines.svh =====
`ifndef I2C_MASTER_REGISTER_SEQUENCER_UNIT_DEFINES_SVH
`define I2C_MASTER_REGISTER_SEQUENCER_UNIT_DEFINES_SVH

// Checked at every edge, reset included.
`define I2CMS_ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |-> (cons)) else $error(msg);

// Same-cycle implication, ignored while reset is held.
`define I2CMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/i2cms_pkg.sv =====
package i2cms_pkg;

    localparam int MAX_BYTES = 16;
    localparam logic [4:0] MAX_CNT = (MAX_BYTES > 31) ? 5'd31 : 5'(MAX_BYTES);

    typedef enum logic [1:0] {
        CMD_BEGIN_W,
        CMD_BEGIN_R,
        CMD_EVENT,
        CMD_NOP
    } t_cmd;

    typedef enum logic [1:0] {
        OP_BEGIN_W = 2'd0,
        OP_BEGIN_R = 2'd1,
        OP_EVENT   = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_START  = 3'd1,
        ACT_ADDR_W = 3'd2,
        ACT_ADDR_R = 3'd3,
        ACT_BYTE   = 3'd4,
        ACT_STOP   = 3'd5
    } t_action;

    typedef enum logic [3:0] {
        PH_UNINIT    = 4'd0,
        PH_W_START   = 4'd1,
        PH_W_ADDR    = 4'd2,
        PH_W_DATA    = 4'd3,
        PH_W_DONE    = 4'd4,
        PH_R_START   = 4'd5,
        PH_R_ADDR    = 4'd6,
        PH_R_REG     = 4'd7,
        PH_R_RESTART = 4'd8,
        PH_R_ADDR2   = 4'd9,
        PH_R_DATA    = 4'd10,
        PH_R_DONE    = 4'd11,
        PH_ERROR     = 4'd12
    } t_phase;

    typedef enum logic [1:0] {
        CFG_DEV_ADDR  = 2'd0,
        CFG_START_REG = 2'd1,
        CFG_BYTE_CNT  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_cmd       kind;
        logic       sb;
        logic       addr;
        logic       txe;
        logic       rxne;
        logic [7:0] rxd;
        logic [7:0] txd;
    } t_cmd_item;

    typedef struct packed {
        logic       wen;
        logic [1:0] idx;
        logic [7:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic       done_res;
        logic       error;
        logic [3:0] phase;
        logic [3:0] byte_position;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       ack_enable;
        logic       clear_addr;
        logic [7:0] out_byte;
        logic [2:0] action;
    } t_result;

endpackage

// ===== hdl/i2cms_front.sv =====
module i2cms_front
    import i2cms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    output logic        o_push,
    output t_cmd_item   o_item,
    input  logic        i_push_ready
);

    logic      r_vld;
    t_cmd_item r_item;
    t_cmd_item n_item;

    assign o_s_tready = !r_vld || i_push_ready;
    assign o_push     = r_vld;
    assign o_item     = r_item;

    always_comb begin
        n_item.sb   = i_s_tdata[0];
        n_item.addr = i_s_tdata[1];
        n_item.txe  = i_s_tdata[2];
        n_item.rxne = i_s_tdata[3];
        n_item.rxd  = i_s_tdata[11:4];
        n_item.txd  = i_s_tdata[19:12];
        case (t_op'(i_s_tuser))
            OP_BEGIN_W: n_item.kind = CMD_BEGIN_W;
            OP_BEGIN_R: n_item.kind = CMD_BEGIN_R;
            OP_EVENT:   n_item.kind = CMD_EVENT;
            default:    n_item.kind = CMD_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== hdl/i2cms_queue.sv =====
module i2cms_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_push_ready,
    output logic             o_pop_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_wr, w_rd;

    assign o_push_ready = (r_cnt != CW'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_data       = r_mem[r_rd];
    assign w_wr         = i_push && o_push_ready;
    assign w_rd         = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hdl/i2cms_back.sv =====
module i2cms_back
    import i2cms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg_wr     i_cfg,
    input  logic        i_cmd_valid,
    input  t_cmd_item   i_cmd,
    output logic        o_pop,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata
);

    logic [7:0] r_dev, r_reg;
    logic [4:0] r_cnt;

    t_phase     r_phase, n_phase;
    logic [4:0] r_left, n_left;
    logic [4:0] r_ptr, n_ptr;
    logic       r_ack, n_ack;

    logic       r_out_vld;
    t_result    r_res, n_res;

    assign o_pop      = i_cmd_valid && (!r_out_vld || i_m_tready);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev <= '0;
            r_reg <= '0;
            r_cnt <= '0;
        end else if (i_cfg.wen) begin
            case (t_cfg_idx'(i_cfg.idx))
                CFG_DEV_ADDR:  r_dev <= i_cfg.data;
                CFG_START_REG: r_reg <= i_cfg.data;
                CFG_BYTE_CNT:  r_cnt <= i_cfg.data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_UNINIT;
            r_left  <= '0;
            r_ptr   <= '0;
            r_ack   <= 1'b0;
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_ptr   <= n_ptr;
            r_ack   <= n_ack;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_pop) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    always_comb begin
        t_action    act;
        logic [7:0] obyte;
        logic       clr, rxv, done;
        logic [7:0] rxb;
        logic [3:0] pos;

        n_phase = r_phase;
        n_left  = r_left;
        n_ptr   = r_ptr;
        n_ack   = r_ack;
        act     = ACT_NONE;
        obyte   = '0;
        clr     = 1'b0;
        rxv     = 1'b0;
        rxb     = '0;
        pos     = '0;
        done    = 1'b0;

        case (i_cmd.kind)
            CMD_BEGIN_W, CMD_BEGIN_R: begin
                n_left  = (r_cnt > MAX_CNT) ? MAX_CNT : r_cnt;
                n_ptr   = '0;
                n_phase = (i_cmd.kind == CMD_BEGIN_W) ? PH_W_START : PH_R_START;
                act     = ACT_START;
            end
            CMD_EVENT: begin
                case (r_phase)
                    PH_UNINIT: n_phase = PH_ERROR;
                    PH_W_START, PH_R_START: begin
                        if (i_cmd.sb) begin
                            if (r_phase == PH_R_START) begin
                                n_ack = 1'b1;
                            end
                            act     = ACT_ADDR_W;
                            obyte   = {r_dev[7:1], 1'b0};
                            n_phase = (r_phase == PH_W_START) ? PH_W_ADDR : PH_R_ADDR;
                        end else begin
                            n_phase = PH_ERROR;
                        end
                    end
                    PH_W_ADDR, PH_R_ADDR: begin
                        if (i_cmd.addr) begin
                            clr     = 1'b1;
                            act     = ACT_BYTE;
                            obyte   = r_reg;
                            n_phase = (r_phase == PH_W_ADDR) ? PH_W_DATA : PH_R_REG;
                        end else begin
                            n_phase = PH_ERROR;
                        end
                    end
                    PH_W_DATA: begin
                        if (!i_cmd.txe) begin
                            n_phase = PH_ERROR;
                        end else if (r_left != '0) begin
                            act    = ACT_BYTE;
                            obyte  = i_cmd.txd;
                            pos    = r_ptr[3:0];
                            n_ptr  = r_ptr + 1'b1;
                            n_left = r_left - 1'b1;
                        end else begin
                            act     = ACT_STOP;
                            done    = 1'b1;
                            n_phase = PH_W_DONE;
                        end
                    end
                    PH_R_REG: begin
                        if (i_cmd.txe) begin
                            act     = ACT_START;
                            n_phase = PH_R_RESTART;
                        end else begin
                            n_phase = PH_ERROR;
                        end
                    end
                    // repeated start not seen yet: keep waiting
                    PH_R_RESTART: begin
                        if (i_cmd.sb) begin
                            act     = ACT_ADDR_R;
                            obyte   = {r_dev[7:1], 1'b1};
                            n_phase = PH_R_ADDR2;
                        end
                    end
                    PH_R_ADDR2: begin
                        if (i_cmd.addr) begin
                            if (r_left == 5'd1) begin
                                n_ack = 1'b0;
                            end
                            clr     = 1'b1;
                            n_phase = PH_R_DATA;
                        end else begin
                            n_phase = PH_ERROR;
                        end
                    end
                    PH_R_DATA: begin
                        if (!i_cmd.rxne) begin
                            n_phase = PH_ERROR;
                        end else if (r_left == '0) begin
                            act     = ACT_STOP;
                            done    = 1'b1;
                            n_phase = PH_R_DONE;
                        end else begin
                            rxv    = 1'b1;
                            rxb    = i_cmd.rxd;
                            pos    = r_ptr[3:0];
                            n_ptr  = r_ptr + 1'b1;
                            n_left = r_left - 1'b1;
                            // NACK goes out on the last byte
                            if (r_left == 5'd2) begin
                                n_ack = 1'b0;
                            end
                            if (r_left == 5'd1) begin
                                act     = ACT_STOP;
                                done    = 1'b1;
                                n_phase = PH_R_DONE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        n_res.action        = act;
        n_res.out_byte      = obyte;
        n_res.clear_addr    = clr;
        n_res.ack_enable    = n_ack;
        n_res.rx_valid      = rxv;
        n_res.rx_byte       = rxb;
        n_res.byte_position = pos;
        n_res.phase         = n_phase;
        n_res.error         = (n_phase == PH_ERROR);
        n_res.done_res      = done;
    end

endmodule

// ===== hdl/i2c_master_register_sequencer_unit.sv =====
// Path: an accepted input is registered in the front stage, written to the queue, then popped into the result register.
// Throughput: one item per cycle while the output is not stalled; every item yields exactly one result.
// The queue of QUEUE_DEPTH commands absorbs output stalls; input stalls once it fills.
// Reset (synchronous, active low) clears config, phase, counters, queue and valids.
`include "i2c_master_register_sequencer_unit_defines.svh"

module i2c_master_register_sequencer_unit
    import i2cms_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // sb, addr, txe, rxne, rx_data[7:0], tx_data[7:0], zero pad
    input  logic [23:0] i_s_tdata,
    // op[1:0]
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // action[2:0], out_byte[7:0], clear_addr, ack_enable, rx_valid, rx_byte[7:0],
    // byte_position[3:0], phase[3:0], error, done_res
    output logic [31:0] o_m_tdata,
    input  logic        i_cfg_wen,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata
);

    localparam int ItemW = $bits(t_cmd_item);

    logic      w_push, w_push_ready, w_pop_valid, w_pop;
    t_cmd_item w_front_item, w_back_item;
    t_cfg_wr   w_cfg;

    assign w_cfg.wen  = i_cfg_wen;
    assign w_cfg.idx  = i_cfg_idx;
    assign w_cfg.data = i_cfg_wdata;

    i2cms_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .o_push       (w_push),
        .o_item       (w_front_item),
        .i_push_ready (w_push_ready)
    );

    i2cms_queue #(
        .WIDTH (ItemW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_data       (w_front_item),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .i_pop        (w_pop),
        .o_data       (w_back_item)
    );

    i2cms_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd_valid (w_pop_valid),
        .i_cmd       (w_back_item),
        .o_pop       (w_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    `I2CMS_ASSERT_ALWAYS(a_out_clear_after_rst, !i_rst_n ##1 1'b1, !o_m_tvalid,
        "result valid after reset")
    `I2CMS_ASSERT_NOW(a_new_result_popped, $rose(o_m_tvalid), $past(w_pop),
        "result without queued command")
    `I2CMS_ASSERT_NOW(a_rx_in_read_phase, o_m_tvalid && o_m_tdata[13],
        o_m_tdata[29:26] == PH_R_DATA || o_m_tdata[29:26] == PH_R_DONE,
        "byte stored outside read data phase")
    `I2CMS_ASSERT_NOW(a_done_is_stop, o_m_tvalid && o_m_tdata[31],
        o_m_tdata[2:0] == ACT_STOP, "done without stop action")

endmodule
